// ===== rtl/iirlp_pkg.sv =====
package iirlp_pkg;

   localparam int COEF_W = 20;
   localparam int SAMPLE_W = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int DEF_COEF_FRAC_BITS = 16;

   // Samples the filter needs, the current one included, before it produces real output.
   localparam int WARMUP_SAMPLES = 3;
   localparam int HELD_W = $clog2(WARMUP_SAMPLES + 1);

   typedef enum logic {
      ACT_SAMPLE = 1'b0,
      ACT_CLEAR  = 1'b1
   } action_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_A0 = 3'd0,
      CSR_A1 = 3'd1,
      CSR_A2 = 3'd2,
      CSR_B1 = 3'd3,
      CSR_B2 = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [COEF_W-1:0] a0;
      logic [COEF_W-1:0] a1;
      logic [COEF_W-1:0] a2;
      logic [COEF_W-1:0] b1;
      logic [COEF_W-1:0] b2;
   } coef_set_type;

endpackage

// ===== rtl/iirlp_csr.sv =====
module iirlp_csr
   import iirlp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]      csr_wdata,
   output coef_set_type           coef
);

   coef_set_type coef_ff;
   coef_set_type coef_in;

   always_comb begin
      coef_in = coef_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_A0:  coef_in.a0 = csr_wdata;
            CSR_A1:  coef_in.a1 = csr_wdata;
            CSR_A2:  coef_in.a2 = csr_wdata;
            CSR_B1:  coef_in.b1 = csr_wdata;
            CSR_B2:  coef_in.b2 = csr_wdata;
            default: coef_in = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign coef = coef_ff;

endmodule

// ===== rtl/iirlp_mac.sv =====
module iirlp_mac
   import iirlp_pkg::*;
#(
   parameter int FRAC_BITS = DEF_COEF_FRAC_BITS,
   parameter int FB_W = 18 + FRAC_BITS
)
(
   input  coef_set_type               coef,
   input  logic signed [SAMPLE_W-1:0] x0,
   input  logic signed [SAMPLE_W-1:0] x1,
   input  logic signed [SAMPLE_W-1:0] x2,
   input  logic signed [FB_W-1:0]     y1,
   input  logic signed [FB_W-1:0]     y2,
   output logic signed [FB_W-1:0]     y_fb,
   output logic signed [SAMPLE_W-1:0] y_out
);

   localparam int PF_W = COEF_W + SAMPLE_W;
   localparam int FF_W = PF_W + 2;
   localparam int PB_W = COEF_W + FB_W;
   localparam int ACC_W = FF_W + FRAC_BITS + 3;

   localparam logic signed [ACC_W-1:0] FB_MAX =
      {{(ACC_W - FB_W + 1){1'b0}}, {(FB_W - 1){1'b1}}};
   localparam logic signed [ACC_W-1:0] FB_MIN = ~FB_MAX;
   localparam logic signed [ACC_W-1:0] OUT_MAX =
      {{(ACC_W - SAMPLE_W + 1){1'b0}}, {(SAMPLE_W - 1){1'b1}}};
   localparam logic signed [ACC_W-1:0] OUT_MIN = ~OUT_MAX;

   logic signed [PF_W-1:0]  p0;
   logic signed [PF_W-1:0]  p1;
   logic signed [PF_W-1:0]  p2;
   logic signed [PB_W-1:0]  q1;
   logic signed [PB_W-1:0]  q2;
   logic signed [FF_W-1:0]  ff_sum;
   logic signed [ACC_W-1:0] acc;
   logic signed [ACC_W-1:0] quo_f;
   logic signed [ACC_W-1:0] quo_2f;
   logic                    fix_f;
   logic                    fix_2f;

   always_comb begin
      p0 = $signed(coef.a0) * x0;
      p1 = $signed(coef.a1) * x1;
      p2 = $signed(coef.a2) * x2;
      q1 = $signed(coef.b1) * y1;
      q2 = $signed(coef.b2) * y2;

      ff_sum = FF_W'(p0) + FF_W'(p1) + FF_W'(p2);
      // The feedforward sum sits in Q.F and is aligned to the Q.2F feedback products.
      acc = ACC_W'($signed({ff_sum, {FRAC_BITS{1'b0}}})) + ACC_W'(q1) + ACC_W'(q2);

      // An arithmetic shift floors; a negative value with a nonzero remainder
      // moves up by one so that the quotient truncates toward zero.
      fix_f = acc[ACC_W-1] && (|acc[FRAC_BITS-1:0]);
      fix_2f = acc[ACC_W-1] && (|acc[2*FRAC_BITS-1:0]);
      quo_f = (acc >>> FRAC_BITS) + $signed({{(ACC_W-1){1'b0}}, fix_f});
      quo_2f = (acc >>> (2 * FRAC_BITS)) + $signed({{(ACC_W-1){1'b0}}, fix_2f});

      if (quo_f > FB_MAX) begin
         y_fb = FB_MAX[FB_W-1:0];
      end else if (quo_f < FB_MIN) begin
         y_fb = FB_MIN[FB_W-1:0];
      end else begin
         y_fb = quo_f[FB_W-1:0];
      end

      if (quo_2f > OUT_MAX) begin
         y_out = OUT_MAX[SAMPLE_W-1:0];
      end else if (quo_2f < OUT_MIN) begin
         y_out = OUT_MIN[SAMPLE_W-1:0];
      end else begin
         y_out = quo_2f[SAMPLE_W-1:0];
      end
   end

endmodule

// ===== rtl/two_pole_iir_lowpass.sv =====
// Two-pole recursive low-pass filter, direct form I, fixed point.
//
// Input channel req_*: one item per handshake, either a new signed sample
// (req_action low) or a clear of the sample history (req_action high).
// Result channel rsp_*: one item for every sample, none for a clear. The
// first two samples after reset or a clear give rsp_filtered = 0 with
// rsp_warming_up set, and leave the feedback history untouched.
// Coefficients are written through csr_* (index 0..4: a0, a1, a2, b1, b2,
// signed Q3.16); writes to other indexes are dropped. Write them only while
// no item is in flight.
//
// An accepted item lands in the input register; all five products, the sum
// and both saturations are combinational from there, and the result register
// loads as the item moves on. The feedback history closes in that same cycle,
// which lets one item enter every cycle unless a stalled receiver holds a
// result in the result register.
// When the receiver stalls, the result register holds and the input register
// still takes one more item; req_stall rises only while both are occupied.
// A clear passes the input register without needing the result register.
// Reset (synchronous) zeroes the coefficients, both histories and the
// warm-up count, and empties both registers.
module two_pole_iir_lowpass
   import iirlp_pkg::*;
#(
   parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_action,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_filtered,
   output logic                       rsp_warming_up,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [COEF_W-1:0]          csr_wdata
);

   localparam int FB_W = 18 + COEF_FRAC_BITS;

   coef_set_type coef;

   logic                       s1_valid_ff, s1_valid_in;
   logic                       s1_action_ff;
   logic signed [SAMPLE_W-1:0] s1_sample_ff;

   logic signed [SAMPLE_W-1:0] xh0_ff, xh0_in;
   logic signed [SAMPLE_W-1:0] xh1_ff, xh1_in;
   logic [HELD_W-1:0]          held_ff, held_in;
   logic signed [FB_W-1:0]     yh0_ff, yh0_in;
   logic signed [FB_W-1:0]     yh1_ff, yh1_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_filtered_ff, rsp_filtered_in;
   logic                       rsp_warm_ff, rsp_warm_in;

   logic                       req_take;
   logic                       s1_adv;
   logic                       s1_is_sample;
   logic                       warm;
   logic signed [FB_W-1:0]     mac_fb;
   logic signed [SAMPLE_W-1:0] mac_out;

   iirlp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .coef      (coef)
   );

   iirlp_mac #(
      .FRAC_BITS (COEF_FRAC_BITS),
      .FB_W      (FB_W)
   ) u_mac (
      .coef  (coef),
      .x0    (s1_sample_ff),
      .x1    (xh0_ff),
      .x2    (xh1_ff),
      .y1    (yh0_ff),
      .y2    (yh1_ff),
      .y_fb  (mac_fb),
      .y_out (mac_out)
   );

   assign s1_is_sample = (s1_action_ff == ACT_SAMPLE);
   assign s1_adv = s1_valid_ff && (!s1_is_sample || !rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_take = req_valid && !req_stall;
   assign warm = ((HELD_W + 1)'(held_ff) + 1'b1) < (HELD_W + 1)'(WARMUP_SAMPLES);

   always_comb begin
      s1_valid_in = req_take || (s1_valid_ff && !s1_adv);

      xh0_in = xh0_ff;
      xh1_in = xh1_ff;
      held_in = held_ff;
      yh0_in = yh0_ff;
      yh1_in = yh1_ff;
      rsp_filtered_in = rsp_filtered_ff;
      rsp_warm_in = rsp_warm_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (s1_adv) begin
         if (!s1_is_sample) begin
            xh0_in = '0;
            xh1_in = '0;
            held_in = '0;
         end else begin
            xh0_in = s1_sample_ff;
            xh1_in = xh0_ff;
            rsp_valid_in = 1'b1;
            if (warm) begin
               held_in = held_ff + 1'b1;
               rsp_filtered_in = '0;
               rsp_warm_in = 1'b1;
            end else begin
               held_in = HELD_W'(WARMUP_SAMPLES);
               yh0_in = mac_fb;
               yh1_in = yh0_ff;
               rsp_filtered_in = mac_out;
               rsp_warm_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         held_ff <= '0;
         xh0_ff <= '0;
         xh1_ff <= '0;
         yh0_ff <= '0;
         yh1_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         held_ff <= held_in;
         xh0_ff <= xh0_in;
         xh1_ff <= xh1_in;
         yh0_ff <= yh0_in;
         yh1_ff <= yh1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_action_ff <= req_action;
         s1_sample_ff <= req_sample;
      end
      rsp_filtered_ff <= rsp_filtered_in;
      rsp_warm_ff <= rsp_warm_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_filtered = rsp_filtered_ff;
   assign rsp_warming_up = rsp_warm_ff;

   // A warm-up sample reports zero and leaves the feedback history alone.
   a_warm_result: assert property (@(posedge clock) disable iff (reset)
      s1_adv && s1_is_sample && warm |=>
         rsp_warming_up && (rsp_filtered == '0) && $stable(yh0_ff) && $stable(yh1_ff))
      else $error("warm-up sample produced output or moved feedback history");

   // A clear restarts the warm-up count and keeps the feedback history.
   a_clear_restart: assert property (@(posedge clock) disable iff (reset)
      s1_adv && !s1_is_sample |=> (held_ff == '0) && $stable(yh0_ff) && $stable(yh1_ff))
      else $error("clear did not restart warm-up");

   // Stall only while the input register holds an item that cannot move on.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && s1_is_sample && rsp_valid_ff && rsp_stall)
      else $error("input stalled without a blocked item");

   // A stalled result must not be overwritten by the next item.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !(s1_adv && s1_is_sample))
      else $error("result register loaded while stalled");

   // The warm-up count never passes the number of samples it waits for.
   a_held_range: assert property (@(posedge clock) disable iff (reset)
      (HELD_W + 1)'(held_ff) <= (HELD_W + 1)'(WARMUP_SAMPLES))
      else $error("held sample count out of range");

endmodule

// ===== tb/sv/two_pole_iir_lowpass_tb.sv =====
`timescale 1ns / 1ps

module two_pole_iir_lowpass_tb;
   import iirlp_pkg::*;

   localparam int FRAC = DEF_COEF_FRAC_BITS;
   localparam int FB_W = 18 + FRAC;
   localparam longint ONE_F = longint'(1) << FRAC;
   localparam longint ONE_2F = longint'(1) << (2 * FRAC);
   localparam longint FB_MAX = (longint'(1) << (17 + FRAC)) - 1;
   localparam longint FB_MIN = -FB_MAX - 1;
   localparam longint OUT_MAX = (longint'(1) << (SAMPLE_W - 1)) - 1;
   localparam longint OUT_MIN = -OUT_MAX - 1;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam logic signed [COEF_W-1:0] GAIN_MAX = {1'b0, {(COEF_W-1){1'b1}}};
   localparam logic signed [COEF_W-1:0] GAIN_MIN = {1'b1, {(COEF_W-1){1'b0}}};
   localparam int ONE_GAIN = 1 << FRAC;

   localparam int FIRST_SPARE_INDEX = int'(CSR_B2) + 1;
   localparam int LAST_SPARE_INDEX = (1 << CSR_INDEX_W) - 1;

   localparam int PHASES = 6;
   localparam int ITEMS_PER_PHASE = 320;
   localparam int DRAIN_CYCLES = 6;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int MAX_REPORTS = 10;

   typedef enum {GAINS_GENTLE, GAINS_RANDOM, GAINS_EXTREME} gain_style_type;

   typedef struct {
      action_type                 action;
      logic signed [SAMPLE_W-1:0] sample;
   } filter_input_type;

   typedef struct {
      logic signed [SAMPLE_W-1:0] filtered;
      logic                       warming_up;
   } filter_result_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic                       req_action = ACT_SAMPLE;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_filtered;
   logic                       rsp_warming_up;
   logic                       csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0]     csr_index = '0;
   logic [COEF_W-1:0]          csr_wdata = '0;

   filter_input_type  sample_feed[$];
   filter_result_type expected_outputs[$];

   // Local copy of the filter state and gains.
   logic signed [COEF_W-1:0]   gain_a0 = '0;
   logic signed [COEF_W-1:0]   gain_a1 = '0;
   logic signed [COEF_W-1:0]   gain_a2 = '0;
   logic signed [COEF_W-1:0]   gain_b1 = '0;
   logic signed [COEF_W-1:0]   gain_b2 = '0;
   logic signed [SAMPLE_W-1:0] prev_x [2] = '{'0, '0};
   logic [HELD_W-1:0]          held = '0;
   logic signed [FB_W-1:0]     prev_y [2] = '{'0, '0};

   int sender_idle_pct = 28;
   int receiver_idle_pct = 79;
   int failures = 0;
   int quiet_cycles = 0;

   two_pole_iir_lowpass dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_filtered   (rsp_filtered),
      .rsp_warming_up (rsp_warming_up),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic note_failure(input string what);
      failures++;
      if (failures <= MAX_REPORTS) begin
         $display("%0t: %s", $time, what);
      end
   endtask

   task automatic predict_filter_step(input action_type act,
                                      input logic signed [SAMPLE_W-1:0] x);
      longint            acc;
      longint            fb;
      longint            y;
      filter_result_type r;
      if (act == ACT_CLEAR) begin
         prev_x[0] = '0;
         prev_x[1] = '0;
         held = '0;
      end else if (int'(held) + 1 < WARMUP_SAMPLES) begin
         prev_x[1] = prev_x[0];
         prev_x[0] = x;
         held = held + 1'b1;
         r.filtered = '0;
         r.warming_up = 1'b1;
         expected_outputs.insert(expected_outputs.size(), r);
      end else begin
         // Feedforward terms are in Q.F; scale them up to Q.2F before adding feedback.
         acc = longint'(gain_a0) * longint'(x)
             + longint'(gain_a1) * longint'(prev_x[0])
             + longint'(gain_a2) * longint'(prev_x[1]);
         acc = acc * ONE_F
             + longint'(gain_b1) * longint'(prev_y[0])
             + longint'(gain_b2) * longint'(prev_y[1]);
         fb = acc / ONE_F;
         if (fb > FB_MAX) fb = FB_MAX;
         if (fb < FB_MIN) fb = FB_MIN;
         prev_y[1] = prev_y[0];
         prev_y[0] = fb[FB_W-1:0];
         prev_x[1] = prev_x[0];
         prev_x[0] = x;
         held = HELD_W'(WARMUP_SAMPLES);
         y = acc / ONE_2F;
         if (y > OUT_MAX) y = OUT_MAX;
         if (y < OUT_MIN) y = OUT_MIN;
         r.filtered = y[SAMPLE_W-1:0];
         r.warming_up = 1'b0;
         expected_outputs.insert(expected_outputs.size(), r);
      end
   endtask

   task automatic write_gain(input logic [CSR_INDEX_W-1:0] idx,
                             input logic signed [COEF_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_A0: gain_a0 = value;
         CSR_A1: gain_a1 = value;
         CSR_A2: gain_a2 = value;
         CSR_B1: gain_b1 = value;
         CSR_B2: gain_b2 = value;
         default: ;
      endcase
   endtask

   // An index past the last register must be dropped by the block.
   task automatic finish_gain_writes();
      write_gain(CSR_INDEX_W'($urandom_range(FIRST_SPARE_INDEX, LAST_SPARE_INDEX)),
                 COEF_W'($urandom()));
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic signed [COEF_W-1:0] pick_gain(input gain_style_type style,
                                                          input int idx);
      logic signed [COEF_W-1:0] g;
      case (style)
         GAINS_GENTLE: begin
            if (idx < int'(CSR_B1)) g = COEF_W'($urandom_range(0, ONE_GAIN / 4));
            else if (idx == int'(CSR_B1))
               g = COEF_W'($urandom_range(ONE_GAIN / 2, ONE_GAIN * 9 / 5));
            else g = COEF_W'(-int'($urandom_range(ONE_GAIN / 8, ONE_GAIN * 9 / 10)));
         end
         GAINS_RANDOM: g = COEF_W'($urandom());
         default: begin
            case ($urandom_range(0, 4))
               0: g = GAIN_MAX;
               1: g = GAIN_MIN;
               2: g = '0;
               3: g = COEF_W'(1);
               default: g = COEF_W'(-1);
            endcase
         end
      endcase
      return g;
   endfunction

   task automatic load_gains(input gain_style_type style);
      for (int i = 0; i <= int'(CSR_B2); i++) begin
         write_gain(CSR_INDEX_W'(i), pick_gain(style, i));
      end
      finish_gain_writes();
   endtask

   task automatic push_sample(input logic signed [SAMPLE_W-1:0] x);
      filter_input_type it;
      it.action = ACT_SAMPLE;
      it.sample = x;
      sample_feed.insert(sample_feed.size(), it);
   endtask

   task automatic push_clear();
      filter_input_type it;
      it.action = ACT_CLEAR;
      it.sample = SAMPLE_W'($urandom());
      sample_feed.insert(sample_feed.size(), it);
   endtask

   task automatic queue_random_items(input int count);
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) push_clear();
         else if (pick < 12) begin
            case ($urandom_range(0, 3))
               0: push_sample(SAMPLE_MAX);
               1: push_sample(SAMPLE_MIN);
               2: push_sample('0);
               default: push_sample(SAMPLE_W'(-1));
            endcase
         end else if (pick < 32) push_sample(SAMPLE_W'(int'($urandom_range(0, 511)) - 256));
         else push_sample(SAMPLE_W'($urandom()));
      end
   endtask

   // Clears give no result, so after the last result a clear may still sit in
   // the block; the extra wait at the end covers it.
   task automatic wait_until_drained();
      do @(negedge clock);
      while (sample_feed.size() != 0 || req_valid || expected_outputs.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   always @(posedge clock) begin : drive_requests
      filter_input_type nxt;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_filter_step(action_type'(req_action), req_sample);
         end
         if (!req_valid || !req_stall) begin
            if (sample_feed.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               nxt = sample_feed.pop_front();
               req_valid <= 1'b1;
               req_action <= nxt.action;
               req_sample <= nxt.sample;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_results
      filter_result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_outputs.size() == 0) begin
               note_failure($sformatf("unexpected result: filtered=%0d warming_up=%0b",
                                      rsp_filtered, rsp_warming_up));
            end else begin
               want = expected_outputs.pop_front();
               if (rsp_filtered !== want.filtered || rsp_warming_up !== want.warming_up) begin
                  note_failure($sformatf(
                     "expected filtered=%0d warming_up=%0b, got filtered=%0d warming_up=%0b",
                     want.filtered, want.warming_up, rsp_filtered, rsp_warming_up));
               end
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      gain_style_type phase_style [PHASES] = '{GAINS_GENTLE, GAINS_RANDOM, GAINS_GENTLE,
                                               GAINS_EXTREME, GAINS_GENTLE, GAINS_RANDOM};
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Large gains drive both the feedback and the output into saturation.
      write_gain(CSR_A0, GAIN_MAX);
      write_gain(CSR_A1, GAIN_MIN);
      write_gain(CSR_A2, COEF_W'(ONE_GAIN / 4));
      write_gain(CSR_B1, GAIN_MAX);
      write_gain(CSR_B2, COEF_W'(-ONE_GAIN / 2));
      finish_gain_writes();
      @(negedge clock);
      push_clear();
      push_sample(SAMPLE_MAX);
      push_clear();
      push_sample(SAMPLE_MIN);
      push_sample(SAMPLE_MAX);
      push_sample(SAMPLE_MIN);
      push_sample(SAMPLE_MAX);
      push_sample('0);
      push_sample(SAMPLE_W'(-1));
      push_sample(SAMPLE_W'(1));
      push_clear();
      push_clear();
      push_sample(SAMPLE_W'(12345));
      push_sample(SAMPLE_W'(-12345));
      push_sample('0);
      push_sample(SAMPLE_MAX);
      wait_until_drained();

      // Tiny gains beside a unit a2: negative sums close to zero must truncate toward zero.
      write_gain(CSR_A0, COEF_W'(-1));
      write_gain(CSR_A1, COEF_W'(1));
      write_gain(CSR_A2, COEF_W'(ONE_GAIN));
      write_gain(CSR_B1, COEF_W'(1));
      write_gain(CSR_B2, '0);
      finish_gain_writes();
      @(negedge clock);
      push_sample(SAMPLE_MIN);
      push_sample(SAMPLE_W'(-1));
      push_sample(SAMPLE_W'(5));
      push_sample(SAMPLE_W'(-7));
      push_sample(SAMPLE_MAX);
      push_sample(SAMPLE_W'(1));

      for (int p = 0; p < PHASES; p++) begin
         wait_until_drained();
         case (p / 2)
            0: begin
               sender_idle_pct = 28;
               receiver_idle_pct = 79;
            end
            1: begin
               sender_idle_pct = 79;
               receiver_idle_pct = 28;
            end
            default: begin
               sender_idle_pct = 0;
               receiver_idle_pct = 0;
            end
         endcase
         load_gains(phase_style[p]);
         @(negedge clock);
         queue_random_items(ITEMS_PER_PHASE);
      end

      wait_until_drained();
      if (failures == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
